FILE: design/message_frame_builder_assert.svh
// Assertion macros for the message frame builder modules.
// Depends on nothing; files that check their own logic include this header.
`ifndef MESSAGE_FRAME_BUILDER_ASSERT_SVH
`define MESSAGE_FRAME_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("message frame builder check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("message frame builder check failed");

`endif

FILE: design/mfb_pkg.sv
// Shared types and constants for the message frame builder.
// Depends on nothing; used by mfb_serializer and message_frame_builder.
package mfb_pkg;

   // Byte position within a frame needs five bits (a frame holds at most 19 bytes).
   localparam int IDX_W = 5;

   localparam logic [7:0] FRAME_FIXED_BYTES = 8'd11;

   // Positions of the frame sections, counted from the first header byte.
   localparam logic [IDX_W-1:0] POS_HDR_LAST = 5'd3;
   localparam logic [IDX_W-1:0] POS_CHANNEL  = 5'd4;
   localparam logic [IDX_W-1:0] POS_LEN_LOW  = 5'd5;
   localparam logic [IDX_W-1:0] POS_LEN_LAST = 5'd8;
   localparam logic [IDX_W-1:0] POS_COMMAND  = 5'd9;
   localparam logic [IDX_W-1:0] POS_PARAM    = 5'd10;

   typedef struct packed {
      logic [7:0]  channel;
      logic [7:0]  command;
      logic [3:0]  count;
      logic [63:0] data;
   } mfb_msg_type;

endpackage

FILE: design/mfb_csr.sv
// Header word register of the message frame builder, written over the csr channel.
// Depends on nothing outside this file.
module mfb_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   output logic [31:0] header_word
);

   logic [31:0] header_ff;
   logic [31:0] header_in;

   assign csr_ready = 1'b1;

   always_comb begin
      header_in = header_ff;
      if (csr_valid) begin
         header_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
      end else begin
         header_ff <= header_in;
      end
   end

   assign header_word = header_ff;

endmodule

FILE: design/mfb_serializer.sv
// Frame serializer: message register, byte position counter, running checksum
// and the output register. Depends on mfb_pkg and message_frame_builder_assert.svh.
`include "message_frame_builder_assert.svh"

module mfb_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         header_word,
   input  logic                load_valid,
   output logic                load_ready,
   input  mfb_pkg::mfb_msg_type load_msg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_byte,
   output logic                rsp_last
);

   mfb_pkg::mfb_msg_type msg_ff, msg_in;
   logic                       busy_ff, busy_in;
   logic [mfb_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]                 sum_ff, sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;

   logic                       advance;
   logic                       at_last;
   logic [mfb_pkg::IDX_W-1:0]  last_idx;
   logic [mfb_pkg::IDX_W-1:0]  param_idx;
   logic [7:0]                 length_low;
   logic [7:0]                 cur_byte;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign last_idx   = mfb_pkg::POS_PARAM + mfb_pkg::IDX_W'(msg_ff.count);
   assign at_last    = (idx_ff == last_idx);
   assign param_idx  = idx_ff - mfb_pkg::POS_PARAM;
   assign length_low = mfb_pkg::FRAME_FIXED_BYTES + {4'd0, msg_ff.count};
   assign load_ready = !busy_ff || (advance && at_last);

   // Byte at the current frame position; the checksum closes the frame.
   always_comb begin
      cur_byte = 8'd0;
      if (at_last) begin
         cur_byte = sum_ff;
      end else begin
         case (idx_ff) inside
            [5'd0:mfb_pkg::POS_HDR_LAST]: begin
               cur_byte = header_word[8*idx_ff[1:0] +: 8];
            end
            mfb_pkg::POS_CHANNEL: begin
               cur_byte = msg_ff.channel;
            end
            mfb_pkg::POS_LEN_LOW: begin
               cur_byte = length_low;
            end
            [mfb_pkg::POS_LEN_LOW+5'd1:mfb_pkg::POS_LEN_LAST]: begin
               // The length never exceeds one byte, so its upper bytes are zero.
               cur_byte = 8'd0;
            end
            mfb_pkg::POS_COMMAND: begin
               cur_byte = msg_ff.command;
            end
            default: begin
               cur_byte = msg_ff.data[8*param_idx[2:0] +: 8];
            end
         endcase
      end
   end

   always_comb begin
      msg_in       = msg_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;

      if (advance) begin
         rsp_valid_in = busy_ff;
         byte_in      = cur_byte;
         last_in      = at_last;
      end

      if (busy_ff && advance) begin
         idx_in = idx_ff + 5'd1;
         sum_in = sum_ff + cur_byte;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end

      // A new message may load in the same cycle the previous checksum leaves.
      if (load_valid && load_ready) begin
         msg_in  = load_msg;
         busy_in = 1'b1;
         idx_in  = '0;
         sum_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff  <= msg_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;

   `MFB_ASSERT_SAME(idx_in_frame, clock, reset, busy_ff, idx_ff <= last_idx)
   `MFB_ASSERT_NEXT(load_starts_frame, clock, reset, load_valid && load_ready,
                    busy_ff && idx_ff == '0 && sum_ff == 8'd0)
   `MFB_ASSERT_NEXT(checksum_marked_last, clock, reset, busy_ff && advance && at_last,
                    rsp_valid_ff && last_ff)
   `MFB_ASSERT_NEXT(body_not_last, clock, reset, busy_ff && advance && !at_last,
                    rsp_valid_ff && !last_ff)

endmodule

FILE: design/message_frame_builder.sv
// Message frame builder: turns one message into a header, channel, length, command,
// parameter and checksum byte frame, one byte per rsp transfer.
// A req transfer loads the message register; the first byte then passes to the output
// register. A frame of 11 + N bytes (19 at most) leaves through the single-byte output
// register, and the next message loads as the checksum leaves.
// Reset clears the header word to zero and empties the message and output registers.
module message_frame_builder #(
   parameter int MAX_PARAM_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] channel, [15:8] command, [19:16] param_count, [83:20] param_data, [87:84] zero
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam logic [3:0] MaxCount = 4'(MAX_PARAM_BYTES);

   logic [31:0]          header_word;
   logic [3:0]           req_count;
   mfb_pkg::mfb_msg_type req_msg;

   assign req_count       = req_tdata[19:16];
   assign req_msg.channel = req_tdata[7:0];
   assign req_msg.command = req_tdata[15:8];
   assign req_msg.count   = (req_count > MaxCount) ? MaxCount : req_count;
   assign req_msg.data    = req_tdata[83:20];

   mfb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .header_word (header_word)
   );

   mfb_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .header_word (header_word),
      .load_valid  (req_tvalid),
      .load_ready  (req_tready),
      .load_msg    (req_msg),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_byte    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule
